### sv/alne_pkg.sv
// ----------------------------------------------------------------------------
// alne_pkg
// shared types and constants of the advertising local name extractor
// ----------------------------------------------------------------------------
`default_nettype none

package alne_pkg;

  // field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CFG_SHORT_NAME_TYPE    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_COMPLETE_NAME_TYPE = 2'd1;

  // reset values of the name type registers
  localparam logic [ByteW-1:0] SHORT_NAME_TYPE_RST    = 8'h08;
  localparam logic [ByteW-1:0] COMPLETE_NAME_TYPE_RST = 8'h09;

  // structure walk phase
  typedef enum logic [1:0] {
    PH_LENGTH  = 2'd0,
    PH_TYPE    = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  // configured name types
  typedef struct packed {
    logic [ByteW-1:0] short_name_type;
    logic [ByteW-1:0] complete_name_type;
  } name_types_t;

  // one result item
  typedef struct packed {
    logic [ByteW-1:0] name_byte;
    logic             byte_valid;
    logic             end_of_record_result;
    logic             found;
    logic             truncated;
  } result_t;

endpackage

`default_nettype wire

### sv/alne_cfg_regs.sv
// ----------------------------------------------------------------------------
// alne_cfg_regs
// name type registers behind the plain write port
// ----------------------------------------------------------------------------
`default_nettype none

module alne_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [alne_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [alne_pkg::CfgDataW-1:0]  cfg_data_i,
  output alne_pkg::name_types_t               types_o
);

  alne_pkg::name_types_t types_q, types_d;

  always_comb begin
    types_d = types_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        alne_pkg::CFG_SHORT_NAME_TYPE:    types_d.short_name_type    = cfg_data_i;
        alne_pkg::CFG_COMPLETE_NAME_TYPE: types_d.complete_name_type = cfg_data_i;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      types_q.short_name_type    <= alne_pkg::SHORT_NAME_TYPE_RST;
      types_q.complete_name_type <= alne_pkg::COMPLETE_NAME_TYPE_RST;
    end else begin
      types_q <= types_d;
    end
  end

  assign types_o = types_q;

endmodule

`default_nettype wire

### sv/alne_parser.sv
// ----------------------------------------------------------------------------
// alne_parser
// walks length-type-payload structures, one byte per accepted transfer
// ----------------------------------------------------------------------------
`default_nettype none

module alne_parser (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         accept_i,
  input  wire logic [alne_pkg::ByteW-1:0]   ad_byte_i,
  input  wire logic                         record_last_i,
  input  wire alne_pkg::name_types_t        types_i,
  output logic                              has_result_o,
  output alne_pkg::result_t                 result_o
);

  alne_pkg::phase_e            phase_q, phase_d;
  logic [alne_pkg::ByteW-1:0]  left_q, left_d;
  logic                        copy_q, copy_d;
  logic                        closed_q, closed_d;

  logic                        match;
  logic                        left_le1;
  logic [alne_pkg::ByteW-1:0]  left_dec;
  logic                        name_end;  // structure-driven close of the search

  assign match    = (ad_byte_i == types_i.short_name_type) ||
                    (ad_byte_i == types_i.complete_name_type);
  assign left_le1 = (left_q <= 8'd1);
  assign left_dec = (left_q != '0) ? left_q - 8'd1 : '0;

  // next state
  always_comb begin
    phase_d  = phase_q;
    left_d   = left_q;
    copy_d   = copy_q;
    closed_d = closed_q;
    name_end = 1'b0;
    if (!closed_q) begin
      unique case (phase_q)
        alne_pkg::PH_TYPE: begin
          if (match) begin
            copy_d = 1'b1;
            if (left_le1) begin
              name_end = 1'b1;
            end else begin
              left_d  = left_dec;
              phase_d = alne_pkg::PH_PAYLOAD;
            end
          end else if (left_le1) begin
            left_d  = '0;
            phase_d = alne_pkg::PH_LENGTH;
          end else begin
            left_d  = left_dec;
            phase_d = alne_pkg::PH_PAYLOAD;
          end
        end
        alne_pkg::PH_PAYLOAD: begin
          left_d = left_dec;
          if (copy_q) begin
            name_end = (left_dec == '0);
          end else if (left_dec == '0) begin
            phase_d = alne_pkg::PH_LENGTH;
          end
        end
        default: begin
          if (ad_byte_i == '0) begin
            name_end = 1'b1;
          end else begin
            left_d  = ad_byte_i;
            phase_d = alne_pkg::PH_TYPE;
          end
        end
      endcase
      if (name_end) begin
        closed_d = 1'b1;
      end
    end
    if (record_last_i) begin
      phase_d  = alne_pkg::PH_LENGTH;
      left_d   = '0;
      copy_d   = 1'b0;
      closed_d = 1'b0;
    end
  end

  // result
  always_comb begin
    result_o = '0;
    if (!closed_q) begin
      if (phase_q == alne_pkg::PH_PAYLOAD && copy_q) begin
        result_o.byte_valid = 1'b1;
        result_o.name_byte  = ad_byte_i;
      end
      if (name_end) begin
        result_o.end_of_record_result = 1'b1;
        // zero length byte closes as not found
        result_o.found = (phase_q != alne_pkg::PH_LENGTH) &&
                         (phase_q != alne_pkg::PH_TYPE || match);
      end else if (record_last_i) begin
        // copy flag as it stands after this byte
        result_o.end_of_record_result = 1'b1;
        result_o.found     = copy_q || (phase_q == alne_pkg::PH_TYPE && match);
        result_o.truncated = copy_q || (phase_q == alne_pkg::PH_TYPE && match);
      end
    end
    has_result_o = result_o.byte_valid || result_o.end_of_record_result;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= alne_pkg::PH_LENGTH;
      left_q   <= '0;
      copy_q   <= 1'b0;
      closed_q <= 1'b0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      left_q   <= left_d;
      copy_q   <= copy_d;
      closed_q <= closed_d;
    end
  end

  // a closed search stays silent until the record ends
  a_closed_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && closed_q) |-> !has_result_o)
    else $error("result after search closed");

  // last byte of a record returns the walk to its start
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && record_last_i) |=>
      (phase_q == alne_pkg::PH_LENGTH && left_q == '0 && !copy_q && !closed_q))
    else $error("state not cleared after record end");

  // name bytes only come from the payload of the name structure
  a_byte_in_name: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && result_o.byte_valid) |->
      (phase_q == alne_pkg::PH_PAYLOAD && copy_q))
    else $error("name byte outside the name payload");

endmodule

`default_nettype wire

### sv/alne_out_queue.sv
// ----------------------------------------------------------------------------
// alne_out_queue
// two-entry result queue that decouples the parser from output stalls
// ----------------------------------------------------------------------------
`default_nettype none

module alne_out_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire alne_pkg::result_t push_data_i,
  output logic                   full_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output alne_pkg::result_t      out_data_o
);

  alne_pkg::result_t mem_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        count_q, count_d;
  logic              pop;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (count_q != 2'd0);
  assign full_o      = (count_q == 2'd2);
  assign out_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue count out of range");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");

  // a stalled result holds until it is taken
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

### sv/adv_local_name_extractor_unit.sv
// ----------------------------------------------------------------------------
// adv_local_name_extractor_unit
// a result is registered in the result queue before it can be taken
// throughput: one byte per cycle while the result queue is not full
// a two-entry result queue keeps input open while one result waits
// reset: async active low; walk state, queue and name types go to defaults
// ----------------------------------------------------------------------------
`default_nettype none

module adv_local_name_extractor_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [alne_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [alne_pkg::CfgDataW-1:0] cfg_data_i,
  // input channel: one record byte per transfer
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [alne_pkg::ByteW-1:0]    ad_byte_i,
  input  wire logic                          record_last_i,
  // output channel: name bytes and the closing result
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [alne_pkg::ByteW-1:0]         name_byte_o,
  output logic                               byte_valid_o,
  output logic                               end_of_record_result_o,
  output logic                               found_o,
  output logic                               truncated_o
);

  alne_pkg::name_types_t types;
  alne_pkg::result_t     step_res;
  alne_pkg::result_t     out_res;
  logic                  has_result;
  logic                  in_accept;
  logic                  queue_full;

  // queue never fills while the output drains every cycle, so bytes
  // stream at full rate; stall comes from a register only
  assign in_stall_o = queue_full;
  assign in_accept  = in_valid_i && !queue_full;

  alne_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .types_o    (types)
  );

  // walk state advances on every accepted byte, whether or not it
  // produces a result
  alne_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .ad_byte_i     (ad_byte_i),
    .record_last_i (record_last_i),
    .types_i       (types),
    .has_result_o  (has_result),
    .result_o      (step_res)
  );

  // only bytes that produce a result enter the queue
  alne_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept && has_result),
    .push_data_i (step_res),
    .full_o      (queue_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_res)
  );

  assign name_byte_o            = out_res.name_byte;
  assign byte_valid_o           = out_res.byte_valid;
  assign end_of_record_result_o = out_res.end_of_record_result;
  assign found_o                = out_res.found;
  assign truncated_o            = out_res.truncated;

endmodule

`default_nettype wire
